### rtl/ascii_integer_parser_assert.svh
// ----------------------------------------------------------------------------
// ascii_integer_parser assertion macros
// Concurrent assertion helpers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clock, off during reset.
`define AIP_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ascii_integer_parser assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define AIP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ascii_integer_parser assertion failed");

`else

`define AIP_ASSERT(label, ante, cons)
`define AIP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared widths, character codes, types and the digit decoder.
// ----------------------------------------------------------------------------
package aip_pkg;

   localparam int VALUE_WIDTH     = 64;
   localparam int OFFSET_WIDTH    = 16;
   localparam int BASE_WIDTH      = 6;
   localparam int CHAR_WIDTH      = 8;
   localparam int DIGIT_WIDTH     = 4;
   localparam int PRODUCT_WIDTH   = VALUE_WIDTH + BASE_WIDTH;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 8;

   // character codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] LETTER_VALUE = 8'd10;

   // radix codes
   localparam logic [BASE_WIDTH-1:0] BASE_AUTO    = 6'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_OCTAL   = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DECIMAL = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX     = 6'd16;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUMBER_BASE = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNED_MODE = 4'd1;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_PRE,
      PH_HEX0,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type               phase;
      logic [VALUE_WIDTH-1:0]  acc;
      logic [BASE_WIDTH-1:0]   base;
      logic                    neg;
      logic [OFFSET_WIDTH-1:0] pos;
      logic                    ovf;
   } str_state_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]  value_bits;
      logic [OFFSET_WIDTH-1:0] end_offset;
      logic                    overflow;
   } result_type;

   typedef struct packed {
      logic [BASE_WIDTH-1:0] number_base;
      logic                  signed_mode;
   } config_type;

   localparam str_state_type STR_STATE_RESET = '{
      phase: PH_SKIP,
      acc:   '0,
      base:  '0,
      neg:   1'b0,
      pos:   '0,
      ovf:   1'b0
   };

   localparam config_type CONFIG_RESET = '{
      number_base: BASE_DECIMAL,
      signed_mode: 1'b1
   };

   // {valid, value} for 0-9, a-f, A-F
   function automatic logic [DIGIT_WIDTH:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
      logic [DIGIT_WIDTH:0]  d;
      logic [CHAR_WIDTH-1:0] diff;
      d    = '0;
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
         d    = {1'b1, diff[DIGIT_WIDTH-1:0]};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         diff = c - CHAR_LOWER_A + LETTER_VALUE;
         d    = {1'b1, diff[DIGIT_WIDTH-1:0]};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         diff = c - CHAR_UPPER_A + LETTER_VALUE;
         d    = {1'b1, diff[DIGIT_WIDTH-1:0]};
      end
      return d;
   endfunction

endpackage

### rtl/aip_ifs.sv
// ----------------------------------------------------------------------------
// aip channel interfaces
// Valid/ready channels for bytes in, results out and register writes.
// ----------------------------------------------------------------------------
interface aip_req_if;
   logic                             valid;
   logic                             ready;
   logic [aip_pkg::CHAR_WIDTH-1:0]   char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface aip_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [aip_pkg::VALUE_WIDTH-1:0]  value_bits;
   logic [aip_pkg::OFFSET_WIDTH-1:0] end_offset;
   logic                             overflow;

   modport source (output valid, output value_bits, output end_offset, output overflow,
                   input ready);
   modport sink   (input valid, input value_bits, input end_offset, input overflow,
                   output ready);
endinterface

interface aip_csr_if;
   logic                                valid;
   logic                                ready;
   logic [aip_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [aip_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming ASCII-to-integer converter, one string byte per word.
// ----------------------------------------------------------------------------
// Feed a string one byte per req word and close it with a zero byte; the zero
// byte produces one rsp word with the 64-bit value (two's complement when a
// '-' was taken in signed mode, wrapping modulo 2^64), the number of bytes
// consumed before parsing stopped (saturating at 65535) and an overflow flag.
// Leading spaces are skipped, signed mode takes one '-' or '+', radix 0 picks
// octal on a leading '0' and decimal otherwise, and radix 16 skips a "0x" or
// "0X" prefix. Bytes after the first non-digit are ignored until the zero
// byte. Throughput is one byte per clock cycle unless a zero byte is held; each
// byte passes through the input register, and the result is valid on rsp the
// cycle after its zero byte leaves that register. A zero byte holds in the
// input register only while an earlier result sits untaken in the result
// register, and bytes behind it wait. The cycle is set by the one accumulator
// times radix multiply-add in aip_step. Registers (number_base index 0,
// signed_mode index 1) are written through csr, which is always ready, and may
// change only while no string is in progress; the user must ensure this.
// ----------------------------------------------------------------------------
`include "ascii_integer_parser_assert.svh"

module ascii_integer_parser (
   input  logic         clock,
   input  logic         reset,
   aip_req_if.sink      req_port,
   aip_rsp_if.source    rsp_port,
   aip_csr_if.sink      csr_port
);

   // input register
   logic                             in_valid_ff;
   logic                             in_valid_in;
   logic [aip_pkg::CHAR_WIDTH-1:0]   char_ff;
   logic [aip_pkg::CHAR_WIDTH-1:0]   char_in;

   // per-string state
   aip_pkg::str_state_type           str_ff;
   aip_pkg::str_state_type           str_in;
   aip_pkg::str_state_type           str_next;

   // result register
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   aip_pkg::result_type              result_ff;
   aip_pkg::result_type              result_in;
   aip_pkg::result_type              step_result;

   // configuration
   aip_pkg::config_type              cfg_ff;
   aip_pkg::config_type              cfg_in;

   logic                             req_take;
   logic                             is_term;
   logic                             consume;

   aip_step u_step (
      .cur_state (str_ff),
      .char_code (char_ff),
      .cfg       (cfg_ff),
      .nxt_state (str_next),
      .result    (step_result)
   );

   // A zero byte waits only when the result register is full and not draining.
   assign is_term  = (char_ff == aip_pkg::CHAR_NUL);
   assign consume  = in_valid_ff && !(is_term && rsp_valid_ff && !rsp_port.ready);
   assign req_take = req_port.valid && req_port.ready;

   assign req_port.ready = !in_valid_ff || consume;
   assign csr_port.ready = 1'b1;

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.value_bits = result_ff.value_bits;
   assign rsp_port.end_offset = result_ff.end_offset;
   assign rsp_port.overflow   = result_ff.overflow;

   always_comb begin
      // input register: load on accept, drop once consumed
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         char_in     = req_port.char_code;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end

      // advance string state per consumed byte
      str_in = consume ? str_next : str_ff;

      // result register: load on terminator, drop once taken
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (consume && is_term) begin
         rsp_valid_in = 1'b1;
         result_in    = step_result;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes, masked to register width; unknown indexes ignored
      cfg_in = cfg_ff;
      if (csr_port.valid && csr_port.ready) begin
         if (csr_port.index == aip_pkg::CSR_NUMBER_BASE) begin
            cfg_in.number_base = csr_port.data[aip_pkg::BASE_WIDTH-1:0];
         end else if (csr_port.index == aip_pkg::CSR_SIGNED_MODE) begin
            cfg_in.signed_mode = csr_port.data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         str_ff       <= aip_pkg::STR_STATE_RESET;
         cfg_ff       <= aip_pkg::CONFIG_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         str_ff       <= str_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      result_ff <= result_in;
   end

   // Consuming a terminator always loads a result.
   `AIP_ASSERT_NEXT(a_term_loads_result, consume && is_term, rsp_valid_ff)
   // Consuming a terminator leaves a fresh string state.
   `AIP_ASSERT_NEXT(a_term_clears_state, consume && is_term,
                    str_ff.phase == aip_pkg::PH_SKIP && str_ff.pos == '0 && str_ff.acc == '0)
   // A stalled byte stays in the input register unchanged.
   `AIP_ASSERT_NEXT(a_stall_holds_byte, in_valid_ff && !consume, in_valid_ff && $stable(char_ff))
   // Overflow only arises while accumulating digits.
   `AIP_ASSERT(a_ovf_only_in_digits, str_ff.ovf,
               str_ff.phase == aip_pkg::PH_DIGITS || str_ff.phase == aip_pkg::PH_DONE)

endmodule

### rtl/aip_step.sv
// ----------------------------------------------------------------------------
// aip_step
// Next string state for one byte, and the result the zero byte produces.
// ----------------------------------------------------------------------------
module aip_step (
   input  aip_pkg::str_state_type          cur_state,
   input  logic [aip_pkg::CHAR_WIDTH-1:0]  char_code,
   input  aip_pkg::config_type             cfg,
   output aip_pkg::str_state_type          nxt_state,
   output aip_pkg::result_type             result
);

   logic [aip_pkg::DIGIT_WIDTH:0]     digit;
   logic                              digit_valid;
   logic [aip_pkg::DIGIT_WIDTH-1:0]   digit_val;
   logic [aip_pkg::BASE_WIDTH-1:0]    first_base;
   logic [aip_pkg::BASE_WIDTH-1:0]    use_base;
   logic                              digit_ok;
   logic [aip_pkg::PRODUCT_WIDTH-1:0] acc_ext;
   logic [aip_pkg::PRODUCT_WIDTH-1:0] base_ext;
   logic [aip_pkg::PRODUCT_WIDTH-1:0] digit_ext;
   logic [aip_pkg::PRODUCT_WIDTH-1:0] product;
   logic [aip_pkg::OFFSET_WIDTH-1:0]  pos_inc;
   logic                              is_sign;
   logic                              do_digit;

   assign digit       = aip_pkg::digit_of(char_code);
   assign digit_valid = digit[aip_pkg::DIGIT_WIDTH];
   assign digit_val   = digit[aip_pkg::DIGIT_WIDTH-1:0];

   // auto radix: leading zero means octal
   assign first_base = (cfg.number_base != aip_pkg::BASE_AUTO) ? cfg.number_base :
                       (char_code == aip_pkg::CHAR_ZERO) ? aip_pkg::BASE_OCTAL :
                                                           aip_pkg::BASE_DECIMAL;
   assign use_base = (cur_state.phase == aip_pkg::PH_SKIP ||
                      cur_state.phase == aip_pkg::PH_PRE) ? first_base : cur_state.base;

   assign digit_ok = digit_valid &&
      ({{(aip_pkg::BASE_WIDTH-aip_pkg::DIGIT_WIDTH){1'b0}}, digit_val} < use_base);

   assign acc_ext   = {{aip_pkg::BASE_WIDTH{1'b0}}, cur_state.acc};
   assign base_ext  = {{aip_pkg::VALUE_WIDTH{1'b0}}, use_base};
   assign digit_ext = {{(aip_pkg::PRODUCT_WIDTH-aip_pkg::DIGIT_WIDTH){1'b0}}, digit_val};
   assign product   = acc_ext * base_ext + digit_ext;

   assign pos_inc = (&cur_state.pos) ? cur_state.pos :
      cur_state.pos + {{(aip_pkg::OFFSET_WIDTH-1){1'b0}}, 1'b1};

   assign is_sign = (char_code == aip_pkg::CHAR_MINUS) || (char_code == aip_pkg::CHAR_PLUS);

   always_comb begin
      result.value_bits = cur_state.neg ? ('0 - cur_state.acc) : cur_state.acc;
      result.end_offset = cur_state.pos;
      result.overflow   = cur_state.ovf;

      nxt_state = cur_state;
      do_digit  = 1'b0;

      case (cur_state.phase)
         aip_pkg::PH_SKIP: begin
            if (char_code == aip_pkg::CHAR_SPACE) begin
               nxt_state.pos = pos_inc;
            end else if (cfg.signed_mode && is_sign) begin
               nxt_state.neg   = (char_code == aip_pkg::CHAR_MINUS);
               nxt_state.pos   = pos_inc;
               nxt_state.phase = aip_pkg::PH_PRE;
            end else if (first_base == aip_pkg::BASE_HEX &&
                         char_code == aip_pkg::CHAR_ZERO) begin
               nxt_state.base  = first_base;
               nxt_state.acc   = '0;
               nxt_state.pos   = pos_inc;
               nxt_state.phase = aip_pkg::PH_HEX0;
            end else begin
               nxt_state.base  = first_base;
               nxt_state.phase = aip_pkg::PH_DIGITS;
               do_digit        = 1'b1;
            end
         end
         aip_pkg::PH_PRE: begin
            nxt_state.base = first_base;
            if (first_base == aip_pkg::BASE_HEX && char_code == aip_pkg::CHAR_ZERO) begin
               nxt_state.acc   = '0;
               nxt_state.pos   = pos_inc;
               nxt_state.phase = aip_pkg::PH_HEX0;
            end else begin
               nxt_state.phase = aip_pkg::PH_DIGITS;
               do_digit        = 1'b1;
            end
         end
         aip_pkg::PH_HEX0: begin
            nxt_state.phase = aip_pkg::PH_DIGITS;
            if (char_code == aip_pkg::CHAR_LOWER_X || char_code == aip_pkg::CHAR_UPPER_X) begin
               nxt_state.pos = pos_inc;
            end else begin
               do_digit = 1'b1;
            end
         end
         aip_pkg::PH_DIGITS: begin
            do_digit = 1'b1;
         end
         default: begin
            nxt_state.phase = aip_pkg::PH_DONE;
         end
      endcase

      // accumulate, or stop on the first non-digit
      if (do_digit) begin
         if (digit_ok) begin
            nxt_state.acc = product[aip_pkg::VALUE_WIDTH-1:0];
            nxt_state.ovf = cur_state.ovf |
                            (|product[aip_pkg::PRODUCT_WIDTH-1:aip_pkg::VALUE_WIDTH]);
            nxt_state.pos = pos_inc;
         end else begin
            nxt_state.phase = aip_pkg::PH_DONE;
         end
      end

      // terminator: start the next string fresh
      if (char_code == aip_pkg::CHAR_NUL) begin
         nxt_state = aip_pkg::STR_STATE_RESET;
      end
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: ascii_integer_parser testbench
// Streams byte strings into the parser and checks every result word against a
// cycle-free predictor of the same string scan. A short directed part comes
// first, then twelve register settings of random strings under changing idle
// and stall patterns.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [aip_pkg::CHAR_WIDTH-1:0]                   char_type;
   typedef logic [aip_pkg::CSR_INDEX_WIDTH-1:0]              csr_idx_type;
   typedef logic [aip_pkg::CSR_DATA_WIDTH-1:0]               csr_data_type;
   typedef logic [aip_pkg::VALUE_WIDTH+aip_pkg::BASE_WIDTH:0] wide_type;

   localparam int PHASES        = 12;
   localparam int PHASE_BYTES   = 40;
   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int IDLE_HEAVY    = 85;
   localparam int IDLE_LIGHT    = 11;
   localparam int MAX_PRINTS    = 50;

   localparam csr_idx_type CSR_FIRST_UNMAPPED =
      aip_pkg::CSR_SIGNED_MODE + {{(aip_pkg::CSR_INDEX_WIDTH-1){1'b0}}, 1'b1};

   logic clock = 1'b0;
   logic reset = 1'b1;

   aip_req_if req_if ();
   aip_rsp_if rsp_if ();
   aip_csr_if csr_if ();

   ascii_integer_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   always #5 clock = ~clock;

   // Byte stream waiting for the driver, and results the parser owes us.
   char_type              byte_feed [$];
   aip_pkg::result_type   expected_results [$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned bytes_queued   = 0;
   int unsigned bytes_fed      = 0;
   int unsigned results_seen   = 0;
   int unsigned overflows_seen = 0;
   int unsigned settings_used  = 1;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;

   // Register mirror, updated at each accepted csr word.
   logic [aip_pkg::BASE_WIDTH-1:0] cfg_base   = aip_pkg::CONFIG_RESET.number_base;
   logic                           cfg_signed = aip_pkg::CONFIG_RESET.signed_mode;

   // Scan state of the string in flight.
   aip_pkg::phase_type               scan_phase = aip_pkg::PH_SKIP;
   logic [aip_pkg::VALUE_WIDTH-1:0]  scan_acc   = '0;
   logic [aip_pkg::BASE_WIDTH-1:0]   scan_radix = '0;
   logic                             scan_neg   = 1'b0;
   logic [aip_pkg::OFFSET_WIDTH-1:0] scan_count = '0;
   logic                             scan_ovf   = 1'b0;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void clear_scan();
      scan_phase = aip_pkg::PH_SKIP;
      scan_acc   = '0;
      scan_radix = '0;
      scan_neg   = 1'b0;
      scan_count = '0;
      scan_ovf   = 1'b0;
   endfunction

   // Count one consumed byte, holding at the top of the field.
   function automatic void bump_count();
      if (scan_count != '1)
         scan_count = scan_count + {{(aip_pkg::OFFSET_WIDTH-1){1'b0}}, 1'b1};
   endfunction

   // Value of a digit character, or -1 for anything else.
   function automatic int digit_value(input char_type c);
      if (c >= aip_pkg::CHAR_ZERO && c <= aip_pkg::CHAR_NINE)
         return int'(c) - int'(aip_pkg::CHAR_ZERO);
      if (c >= aip_pkg::CHAR_LOWER_A && c <= aip_pkg::CHAR_LOWER_F)
         return int'(c) - int'(aip_pkg::CHAR_LOWER_A) + 10;
      if (c >= aip_pkg::CHAR_UPPER_A && c <= aip_pkg::CHAR_UPPER_F)
         return int'(c) - int'(aip_pkg::CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   // Fold one digit into the accumulator, or stop the scan on a non-digit.
   function automatic void take_digit(input char_type c);
      int                              d;
      logic [aip_pkg::DIGIT_WIDTH-1:0] dv;
      wide_type                        wide;
      d = digit_value(c);
      if (d < 0 || d >= int'(scan_radix)) begin
         scan_phase = aip_pkg::PH_DONE;
         return;
      end
      dv   = d[aip_pkg::DIGIT_WIDTH-1:0];
      wide = wide_type'(scan_acc) * wide_type'(scan_radix) + wide_type'(dv);
      // anything above the value field means the magnitude no longer fits
      if (wide[aip_pkg::VALUE_WIDTH+aip_pkg::BASE_WIDTH:aip_pkg::VALUE_WIDTH] != '0)
         scan_ovf = 1'b1;
      scan_acc = wide[aip_pkg::VALUE_WIDTH-1:0];
      bump_count();
   endfunction

   // First byte after spaces and sign: latch the radix, resolve auto mode.
   function automatic void take_first(input char_type c);
      scan_radix = cfg_base;
      if (scan_radix == aip_pkg::BASE_AUTO)
         scan_radix = (c == aip_pkg::CHAR_ZERO) ? aip_pkg::BASE_OCTAL : aip_pkg::BASE_DECIMAL;
      if (scan_radix == aip_pkg::BASE_HEX && c == aip_pkg::CHAR_ZERO) begin
         // leading zero of a possible hex prefix counts as a digit itself
         scan_acc = '0;
         bump_count();
         scan_phase = aip_pkg::PH_HEX0;
      end else begin
         scan_phase = aip_pkg::PH_DIGITS;
         take_digit(c);
      end
   endfunction

   // Advance the scan by one accepted byte; a zero byte closes the string.
   function automatic void predict_byte(input char_type c);
      aip_pkg::result_type res;
      if (c == aip_pkg::CHAR_NUL) begin
         res.value_bits = scan_neg ? ('0 - scan_acc) : scan_acc;
         res.end_offset = scan_count;
         res.overflow   = scan_ovf;
         expected_results.push_back(res);
         clear_scan();
      end else begin
         case (scan_phase)
            aip_pkg::PH_SKIP: begin
               if (c == aip_pkg::CHAR_SPACE) begin
                  bump_count();
               end else if (cfg_signed &&
                            (c == aip_pkg::CHAR_MINUS || c == aip_pkg::CHAR_PLUS)) begin
                  scan_neg = (c == aip_pkg::CHAR_MINUS);
                  bump_count();
                  scan_phase = aip_pkg::PH_PRE;
               end else begin
                  take_first(c);
               end
            end
            aip_pkg::PH_PRE: take_first(c);
            aip_pkg::PH_HEX0: begin
               if (c == aip_pkg::CHAR_LOWER_X || c == aip_pkg::CHAR_UPPER_X) begin
                  bump_count();
                  scan_phase = aip_pkg::PH_DIGITS;
               end else begin
                  scan_phase = aip_pkg::PH_DIGITS;
                  take_digit(c);
               end
            end
            aip_pkg::PH_DIGITS: take_digit(c);
            default: ;   // stopped: drop everything up to the zero byte
         endcase
      end
   endfunction

   // ------------------------------------------------------------------------
   // Reporting
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("tb: result %0d %s: got %h, want %h", results_seen, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Driver: present the next byte whenever the channel is free, unless the
   // idle roll says to hold off this cycle. Predict at the accepting edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_byte(req_if.char_code);
            bytes_fed++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid     <= 1'b1;
               req_if.char_code <= byte_feed.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each accepted result word against the oldest prediction,
   // then roll the stall for the next cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      aip_pkg::result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("arrived with no string closed", rsp_if.value_bits, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.value_bits !== want.value_bits)
                  report_mismatch("value_bits", rsp_if.value_bits, want.value_bits);
               if (rsp_if.end_offset !== want.end_offset)
                  report_mismatch("end_offset", 64'(rsp_if.end_offset),
                                  64'(want.end_offset));
               if (rsp_if.overflow !== want.overflow)
                  report_mismatch("overflow", 64'(rsp_if.overflow), 64'(want.overflow));
               if (want.overflow)
                  overflows_seen++;
            end
            results_seen++;
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: the slowest legal run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic feed_byte(input char_type c);
      byte_feed.push_back(c);
      bytes_queued++;
   endtask

   // Queue a text string and its zero terminator.
   task automatic feed_text(input string s);
      for (int i = 0; i < s.len(); i++)
         feed_byte(s[i]);
      feed_byte(aip_pkg::CHAR_NUL);
   endtask

   // Wait until every queued byte is taken and every result is back, then let
   // the pipeline settle so a register write cannot land on live work.
   task automatic wait_drained();
      while (bytes_fed != bytes_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the mirror follows only at the accepting edge.
   task automatic write_csr(input csr_idx_type idx, input csr_data_type value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      case (idx)
         aip_pkg::CSR_NUMBER_BASE: cfg_base   = value[aip_pkg::BASE_WIDTH-1:0];
         aip_pkg::CSR_SIGNED_MODE: cfg_signed = value[0];
         default: ;   // unmapped index: the parser ignores it
      endcase
      csr_if.valid <= 1'b0;
   endtask

   // Write both registers with junk in the unused data bits.
   task automatic apply_setting(input logic [aip_pkg::BASE_WIDTH-1:0] radix, input logic sgn);
      csr_data_type data;
      data = csr_data_type'($urandom);
      data[aip_pkg::BASE_WIDTH-1:0] = radix;
      write_csr(aip_pkg::CSR_NUMBER_BASE, data);
      data = csr_data_type'($urandom);
      data[0] = sgn;
      write_csr(aip_pkg::CSR_SIGNED_MODE, data);
      settings_used++;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [aip_pkg::BASE_WIDTH-1:0] radix;
      logic                           sgn;
      char_type                       ch;
      csr_idx_type                    junk_idx;
      int                             digit_radix;
      int                             len;
      int                             v;
      int unsigned                    mark;

      // Hold every input at a known level before the first edge.
      req_if.valid     = 1'b0;
      req_if.char_code = aip_pkg::CHAR_NUL;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = aip_pkg::CSR_NUMBER_BASE;
      csr_if.data      = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed strings on the reset setting (decimal, signed): sign and
      // leading space, space after the sign, empty string, lone sign, and
      // junk after the stopping byte.
      feed_text(" -12");
      feed_text("- 5");
      feed_text("");
      feed_text("+");
      feed_text("7q9");
      wait_drained();

      // Hex unsigned: bare prefix, zero with no 'x', and a sign that now stops.
      apply_setting(aip_pkg::BASE_HEX, 1'b0);
      feed_text("0x");
      feed_text("0fG");
      feed_text("-1");
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:  begin radix = aip_pkg::BASE_DECIMAL; sgn = 1'b1; end
            1:  begin radix = aip_pkg::BASE_AUTO;    sgn = 1'b1; end
            2:  begin radix = aip_pkg::BASE_HEX;     sgn = 1'b1; end
            3:  begin radix = 6'd36;                 sgn = 1'b0; end
            4:  begin radix = 6'd1;                  sgn = 1'b1; end
            5:  begin radix = aip_pkg::BASE_OCTAL;   sgn = 1'b0; end
            6:  begin radix = aip_pkg::BASE_AUTO;    sgn = 1'b0; end
            7:  begin radix = 6'd2;                  sgn = 1'b1; end
            8:  begin radix = 6'd17;                 sgn = 1'b1; end
            9:  begin radix = aip_pkg::BASE_DECIMAL; sgn = 1'b0; end
            10: begin radix = aip_pkg::BASE_HEX;     sgn = 1'b0; end
            default: begin radix = aip_pkg::BASE_AUTO; sgn = 1'b1; end
         endcase
         apply_setting(radix, sgn);

         // Every other setting, poke an unmapped index; nothing may change.
         if (p % 2 == 1) begin
            junk_idx = csr_idx_type'($urandom_range(2 ** aip_pkg::CSR_INDEX_WIDTH - 1,
                                                    CSR_FIRST_UNMAPPED));
            write_csr(junk_idx, csr_data_type'($urandom));
         end

         case (p % 4)
            0: begin send_idle_pct = 0;          recv_stall_pct = 0;          end
            1: begin send_idle_pct = IDLE_HEAVY; recv_stall_pct = 0;          end
            2: begin send_idle_pct = 0;          recv_stall_pct = IDLE_HEAVY; end
            default: begin send_idle_pct = IDLE_LIGHT; recv_stall_pct = IDLE_LIGHT; end
         endcase

         // Digits are mostly drawn below the radix in use; letters only go to f.
         if (cfg_base == aip_pkg::BASE_AUTO)
            digit_radix = 10;
         else if (cfg_base > aip_pkg::BASE_HEX)
            digit_radix = 16;
         else
            digit_radix = int'(cfg_base);

         mark = bytes_queued;
         while (bytes_queued - mark < PHASE_BYTES) begin
            if ($urandom_range(99) < 12) begin
               // noise: any nonzero bytes
               len = $urandom_range(8);
               repeat (len) begin
                  ch = char_type'($urandom_range(255, 1));
                  feed_byte(ch);
               end
            end else begin
               repeat ($urandom_range(3)) feed_byte(aip_pkg::CHAR_SPACE);
               case ($urandom_range(3))
                  1: feed_byte(aip_pkg::CHAR_MINUS);
                  2: feed_byte(aip_pkg::CHAR_PLUS);
                  default: ;
               endcase
               // rarely break the string with a space after the sign
               if ($urandom_range(19) == 0)
                  feed_byte(aip_pkg::CHAR_SPACE);
               case ($urandom_range(7))
                  0: begin
                     feed_byte(aip_pkg::CHAR_ZERO);
                     feed_byte(aip_pkg::CHAR_LOWER_X);
                  end
                  1: begin
                     feed_byte(aip_pkg::CHAR_ZERO);
                     feed_byte(aip_pkg::CHAR_UPPER_X);
                  end
                  2: feed_byte(aip_pkg::CHAR_ZERO);
                  default: ;
               endcase
               // mostly short numbers, now and then long enough to overflow
               len = ($urandom_range(4) == 0) ? $urandom_range(25, 14) : $urandom_range(6);
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(15) == 0)
                     v = $urandom_range(15);
                  else
                     v = $urandom_range(digit_radix - 1);
                  if (v < 10)
                     ch = char_type'(int'(aip_pkg::CHAR_ZERO) + v);
                  else if ($urandom_range(1) == 0)
                     ch = char_type'(int'(aip_pkg::CHAR_LOWER_A) + v - 10);
                  else
                     ch = char_type'(int'(aip_pkg::CHAR_UPPER_A) + v - 10);
                  feed_byte(ch);
               end
               // trailing junk after the number, ignored until the terminator
               if ($urandom_range(3) == 0) begin
                  repeat ($urandom_range(3, 1)) begin
                     ch = char_type'($urandom_range(255, 1));
                     feed_byte(ch);
                  end
               end
            end
            feed_byte(aip_pkg::CHAR_NUL);
         end

         // Drain fully before touching the registers again.
         wait_drained();
      end

      $display("tb: %0d bytes in, %0d results checked (%0d with overflow)",
               bytes_fed, results_seen, overflows_seen);
      $display("tb: %0d register settings, radix 0 to 36, signed and unsigned",
               settings_used);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d mismatches", error_count);
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
